// ===== hw/rtl/stbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_pkg
// Shared types and constants for the suffix trie best match unit.
// ----------------------------------------------------------------------------
package stbm_pkg;

    localparam int LET_W = 5;
    localparam int LEN_W = 13;
    localparam int IDX_W = 10;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_QUERY  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INSERT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

    // One letter transaction after classification.
    typedef struct packed {
        logic             is_query;
        logic             letter_ok;
        logic [LET_W-1:0] letter;
        logic [LEN_W-1:0] word_length;
        logic [IDX_W-1:0] word_index;
        logic             word_start;
        logic             word_end;
    } t_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK,
        ST_NODE,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/stbm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_front
// Accepts letter transactions, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module stbm_front import stbm_pkg::*; #(
    parameter int ALPHABET = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_enable,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    t_item      r_fifo [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push, w_pop;

    always_comb begin
        w_item.is_query    = i_s_tuser[0];
        w_item.word_start  = i_s_tuser[1];
        w_item.word_end    = i_s_tlast;
        w_item.letter      = i_s_tdata[LET_W-1:0];
        w_item.word_length = i_s_tdata[LET_W+LEN_W-1:LET_W];
        w_item.word_index  = i_s_tdata[LET_W+LEN_W+IDX_W-1:LET_W+LEN_W];
        w_item.letter_ok   = (32'(i_s_tdata[LET_W-1:0]) < ALPHABET);
    end

    assign o_s_tready   = i_enable && (r_cnt != 2'd2);
    assign w_push       = i_s_tvalid && o_s_tready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign w_pop        = i_pop && o_item_valid;
    assign o_item       = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== hw/rtl/stbm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_back
// Trie engine: child table and node table, walk, insert and result register.
// ----------------------------------------------------------------------------
module stbm_back import stbm_pkg::*; #(
    parameter int NODE_COUNT = 4096,
    parameter int ALPHABET   = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_ready_for_items,
    input  logic              i_item_valid,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [IDX_W-1:0]  o_answer_index,
    output logic [STAT_W-1:0] o_status
);

    localparam int SLOTS  = NODE_COUNT * ALPHABET;
    localparam int LINK_W = $clog2(NODE_COUNT);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = LINK_W + 1;

    logic [LINK_W:0]          r_cmem [SLOTS];
    logic [IDX_W+LEN_W-1:0]   r_nmem [NODE_COUNT];
    logic [LINK_W:0]          r_cq;
    logic [IDX_W+LEN_W-1:0]   r_nq;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [LINK_W-1:0]   r_cursor, n_cursor;
    logic                r_stopped, n_stopped;
    logic                r_overflow, n_overflow;
    logic [IDX_W-1:0]    r_qbest, n_qbest;
    logic [IDX_W-1:0]    r_root_idx, n_root_idx;
    logic [LEN_W-1:0]    r_root_len, n_root_len;
    logic [CNT_W-1:0]    r_used, n_used;
    t_item               r_item, n_item;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_out_valid, n_out_valid;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic [STAT_W-1:0]   r_out_stat, n_out_stat;

    logic                   c_rd, c_we, nd_rd, nd_we;
    logic [SLOT_W-1:0]      c_raddr, c_waddr;
    logic [LINK_W:0]        c_wdata;
    logic [LINK_W-1:0]      nd_raddr, nd_waddr;
    logic [IDX_W+LEN_W-1:0] nd_wdata;
    logic [LINK_W-1:0]      w_cur0;
    logic                   w_stop0;

    always_ff @(posedge i_clk) begin
        if (c_we) r_cmem[c_waddr] <= c_wdata;
        if (c_rd) r_cq <= r_cmem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) r_nmem[nd_waddr] <= nd_wdata;
        if (nd_rd) r_nq <= r_nmem[nd_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cursor    = r_cursor;
        n_stopped   = r_stopped;
        n_overflow  = r_overflow;
        n_qbest     = r_qbest;
        n_root_idx  = r_root_idx;
        n_root_len  = r_root_len;
        n_used      = r_used;
        n_item      = r_item;
        n_slot      = r_slot;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_idx   = r_out_idx;
        n_out_stat  = r_out_stat;
        c_rd = 1'b0; c_we = 1'b0; nd_rd = 1'b0; nd_we = 1'b0;
        c_raddr  = '0;
        c_waddr  = r_clr;
        c_wdata  = '0;
        nd_raddr = r_cq[LINK_W-1:0];
        nd_waddr = r_cursor;
        nd_wdata = {r_item.word_index, r_item.word_length};
        o_pop    = 1'b0;
        w_cur0   = i_item.word_start ? '0 : r_cursor;
        w_stop0  = i_item.word_start ? 1'b0 : r_stopped;

        case (r_state)
            ST_CLEAR: begin
                c_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == SLOT_W'(SLOTS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_cursor = w_cur0;
                    n_stopped = w_stop0;
                    if (i_item.word_start) begin
                        n_overflow = 1'b0;
                        if (i_item.is_query) begin
                            n_qbest = r_root_idx;
                        end else if (i_item.word_length < r_root_len) begin
                            n_root_len = i_item.word_length;
                            n_root_idx = i_item.word_index;
                        end
                    end
                    n_state = ST_DONE;
                    if (!w_stop0) begin
                        if (!i_item.letter_ok) begin
                            if (i_item.is_query) n_stopped = 1'b1;
                        end else begin
                            c_rd    = 1'b1;
                            c_raddr = SLOT_W'(w_cur0) * SLOT_W'(ALPHABET)
                                      + SLOT_W'(i_item.letter);
                            n_slot  = c_raddr;
                            n_state = ST_LINK;
                        end
                    end
                end
            end
            ST_LINK: begin
                n_state = ST_DONE;
                if (r_cq[LINK_W]) begin
                    n_cursor = r_cq[LINK_W-1:0];
                    nd_rd    = 1'b1;
                    n_state  = ST_NODE;
                end else if (r_item.is_query) begin
                    n_stopped = 1'b1;
                end else if (r_used < CNT_W'(NODE_COUNT)) begin
                    // allocate the next free node
                    c_we     = 1'b1;
                    c_waddr  = r_slot;
                    c_wdata  = {1'b1, r_used[LINK_W-1:0]};
                    nd_we    = 1'b1;
                    nd_waddr = r_used[LINK_W-1:0];
                    n_cursor = r_used[LINK_W-1:0];
                    n_used   = r_used + 1'b1;
                end else begin
                    n_overflow = 1'b1;
                    n_stopped  = 1'b1;
                end
            end
            ST_NODE: begin
                if (r_item.is_query) begin
                    n_qbest = r_nq[IDX_W+LEN_W-1:LEN_W];
                end else if (r_item.word_length < r_nq[LEN_W-1:0]) begin
                    nd_we = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_item.word_end) begin
                    n_state = ST_IDLE;
                end else if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_item.is_query ? r_qbest : '0;
                    n_out_stat  = r_item.is_query ? STAT_QUERY :
                                  (r_overflow ? STAT_FULL : STAT_INSERT);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cursor    <= '0;
            r_stopped   <= 1'b0;
            r_overflow  <= 1'b0;
            r_qbest     <= '0;
            r_root_idx  <= '0;
            r_root_len  <= '1;
            r_used      <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cursor    <= n_cursor;
            r_stopped   <= n_stopped;
            r_overflow  <= n_overflow;
            r_qbest     <= n_qbest;
            r_root_idx  <= n_root_idx;
            r_root_len  <= n_root_len;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_slot     <= n_slot;
        r_out_idx  <= n_out_idx;
        r_out_stat <= n_out_stat;
    end

    assign o_ready_for_items = (r_state != ST_CLEAR);
    assign o_m_tvalid        = r_out_valid;
    assign o_answer_index    = r_out_idx;
    assign o_status          = r_out_stat;

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used >= CNT_W'(1)) && (r_used <= CNT_W'(NODE_COUNT)))
        else $error("node pool count out of range");
    a_overflow_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> r_stopped)
        else $error("overflow without stopped walk");
    a_link_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LINK) |-> $past(r_state) == ST_IDLE)
        else $error("link lookup not started from idle");
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_pop)
        else $error("item taken during clearing pass");

endmodule

// ===== hw/rtl/suffix_trie_best_match_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_trie_best_match_unit
// Suffix trie in a bounded node pool with shortest-word best match lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one letter per transaction, each word sent last letter
//   first. tuser marks the kind (insert or query) and the word start, tlast
//   marks the final letter of a word. Stored words go first, then queries.
//   Master channel: one transaction per word, on its final letter, carrying
//   the best stored index (queries) and a status code.
//   Sequencing: each letter passes IDLE, LINK and DONE when its child is
//   missing, IDLE, LINK, NODE and DONE when it finds a child (the node table
//   is read after the child table), and IDLE then DONE on a stopped walk or
//   an out-of-range letter. The engine takes the next letter from the queue
//   only in IDLE; a word's result is loaded into the output register in DONE
//   of its final letter.
//   A two-entry queue lets the slave side keep accepting while the engine works,
//   and an output register holds a finished result while the receiver stalls;
//   the engine waits only when that register is still full.
//   Reset: after i_rst_n the child table is cleared one slot per cycle,
//   NODE_COUNT*ALPHABET slots (106496 by default), with tready held low.
// ----------------------------------------------------------------------------
module suffix_trie_best_match_unit import stbm_pkg::*; #(
    parameter int NODE_COUNT = 4096,
    parameter int ALPHABET   = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // letter[4:0], word_length[17:5], word_index[27:18]
    input  logic [1:0]  i_s_tuser,   // func[0], word_start[1]
    input  logic        i_s_tlast,   // word_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // answer_index[9:0]
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    logic              w_ready_for_items;
    logic              w_item_valid;
    t_item             w_item;
    logic              w_pop;
    logic [IDX_W-1:0]  w_answer;
    logic [STAT_W-1:0] w_status;

    // Front: accept and classify, queue toward the engine.
    stbm_front #(.ALPHABET(ALPHABET)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (w_ready_for_items),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    // Back: walk or extend the trie, drive the result register.
    stbm_back #(.NODE_COUNT(NODE_COUNT), .ALPHABET(ALPHABET)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .o_ready_for_items (w_ready_for_items),
        .i_item_valid      (w_item_valid),
        .i_item            (w_item),
        .o_pop             (w_pop),
        .o_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .o_answer_index    (w_answer),
        .o_status          (w_status)
    );

    assign o_m_tdata = {{(16-IDX_W){1'b0}}, w_answer};
    assign o_m_tuser = w_status;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the suffix trie best match unit.
// Letters of stored words and then of query words stream into the slave side.
// A trie model in the scoreboard predicts the result of every word end, and
// each master transaction is compared with the oldest prediction. Both sides
// idle at random. At the end stored words are replayed as clean words of
// both kinds.
// ----------------------------------------------------------------------------
module tb_top;
    import stbm_pkg::*;

    localparam int NODES    = 4096;
    localparam int LETTERS  = 26;
    localparam int SLOTS    = NODES * LETTERS;
    localparam int IDLE_CAP = 500000;  // covers the child table clear after reset

    typedef struct packed {
        logic [IDX_W-1:0]  answer;
        logic [STAT_W-1:0] status;
    } t_word_result;

    // Trie model plus the queue of pending word results.
    class trie_scoreboard;
        bit           present[SLOTS];
        int           link[SLOTS];
        int           best_idx[NODES];
        int           best_len[NODES];
        int           root_idx, root_len, nodes_used, cursor, query_best;
        bit           stopped, overflow;
        t_word_result pending_q[$];
        int           errors;

        function new();
            root_idx   = 0;
            root_len   = 8191;
            nodes_used = 1;
            cursor     = 0;
            query_best = 0;
            stopped    = 0;
            overflow   = 0;
            errors     = 0;
        endfunction

        // Advance the trie by one accepted letter; queue a result on a word end.
        function void note_letter(bit is_query, logic [LET_W-1:0] letter,
                                  logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx,
                                  bit start, bit last);
            int           s;
            int           n;
            t_word_result r;
            if (start) begin
                cursor   = 0;
                stopped  = 0;
                overflow = 0;
                if (is_query) begin
                    query_best = root_idx;
                end else if (int'(len) < root_len) begin
                    root_len = len;
                    root_idx = idx;
                end
            end
            if (!stopped) begin
                s = (letter < LETTERS) ? cursor * LETTERS + letter : -1;
                if (is_query) begin
                    if (s >= 0 && present[s]) begin
                        cursor     = link[s];
                        query_best = best_idx[cursor];
                    end else begin
                        stopped = 1;
                    end
                end else if (s >= 0) begin
                    if (present[s]) begin
                        n      = link[s];
                        cursor = n;
                        if (int'(len) < best_len[n]) begin
                            best_len[n] = len;
                            best_idx[n] = idx;
                        end
                    end else if (nodes_used < NODES) begin
                        n           = nodes_used;
                        nodes_used  = n + 1;
                        link[s]     = n;
                        present[s]  = 1;
                        best_idx[n] = idx;
                        best_len[n] = len;
                        cursor      = n;
                    end else begin
                        overflow = 1;
                        stopped  = 1;
                    end
                end
            end
            if (last) begin
                r.answer = is_query ? query_best[IDX_W-1:0] : '0;
                r.status = is_query ? STAT_QUERY : (overflow ? STAT_FULL : STAT_INSERT);
                pending_q.push_back(r);
            end
        endfunction

        function void check_result(logic [IDX_W-1:0] answer, logic [STAT_W-1:0] status);
            t_word_result r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result answer=%0d status=%0d", $time, answer, status);
                errors++;
                return;
            end
            r = pending_q.pop_front();
            if (answer !== r.answer) begin
                $display("%0t: answer_index expected %0d actual %0d", $time, r.answer, answer);
                errors++;
            end
            if (status !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, status);
                errors++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = '0;
    logic        i_s_tlast  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    trie_scoreboard sb = new();

    int  idle_cycles = 0;
    int  results_seen = 0;
    bit  long_hold_done = 0;

    // Stored word bank, kept in send order (last letter first).
    int  bank[256][8];
    int  bank_len[256];
    int  bank_count = 0;

    suffix_trie_best_match_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // letter[4:0], word_length[17:5], word_index[27:18]
        .i_s_tuser  (i_s_tuser),   // func[0], word_start[1]
        .i_s_tlast  (i_s_tlast),   // word_end
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // answer_index[9:0]
        .o_m_tuser  (o_m_tuser)    // status[1:0]
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one letter; return at the edge that accepts it.
    task automatic send_letter(bit is_query, logic [LET_W-1:0] letter,
                               logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx,
                               bit start, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, idx, len, letter};
        i_s_tuser  <= {start, is_query};
        i_s_tlast  <= last;
        do begin
            @(negedge i_clk);
        end while (!o_s_tready);
        sb.note_letter(is_query, letter, len, idx, start, last);
        @(posedge i_clk);
    endtask

    // Send a whole word with occasional damage: lost start, lost end,
    // a flipped kind, an out-of-range letter or a random raw length.
    task automatic send_word(bit is_query, int letters[8], int n, logic [IDX_W-1:0] idx,
                             bit noisy);
        logic [LEN_W-1:0] len;
        bit               start_ok, end_ok;
        int               flip_at, bad_at;
        logic [LET_W-1:0] c;
        len      = LEN_W'(n);
        start_ok = 1;
        end_ok   = 1;
        flip_at  = -1;
        bad_at   = -1;
        if (noisy) begin
            if ($urandom_range(0, 99) < 15) len = LEN_W'($urandom_range(0, 8191));
            if ($urandom_range(0, 99) < 5) start_ok = 0;
            if ($urandom_range(0, 99) < 5) end_ok = 0;
            if ($urandom_range(0, 99) < 4) flip_at = $urandom_range(0, n - 1);
            if ($urandom_range(0, 99) < 4) bad_at = $urandom_range(0, n - 1);
        end
        for (int i = 0; i < n; i++) begin
            c = (i == bad_at) ? LET_W'($urandom_range(26, 31)) : LET_W'(letters[i]);
            send_letter(is_query ^ (i == flip_at), c, len, idx,
                        start_ok && i == 0, end_ok && i == n - 1);
        end
    endtask

    // Drop tvalid, then hold until every expected result has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int w[8];
        int n, k, b;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of length and index, out-of-range letters,
        // missing children, no word start, mixed kinds within a word.
        send_letter(0, 5'd0, 13'd8191, 10'd7, 1, 1);     // never displaces root reset
        send_letter(0, 5'd0, 13'd1, 10'd5, 1, 1);
        send_letter(0, 5'd25, 13'd2, 10'd1023, 1, 0);
        send_letter(0, 5'd24, 13'd2, 10'd1023, 0, 1);
        send_letter(0, 5'd31, 13'd0, 10'd0, 1, 1);       // out of range insert
        send_letter(0, 5'd26, 13'd3, 10'd512, 1, 0);
        send_letter(0, 5'd25, 13'd3, 10'd512, 0, 1);
        send_letter(1, 5'd0, 13'd1, 10'd0, 1, 1);
        send_letter(1, 5'd25, 13'd2, 10'd1023, 1, 0);
        send_letter(1, 5'd24, 13'd2, 10'd0, 0, 1);
        send_letter(1, 5'd7, 13'd1, 10'd0, 1, 1);        // missing child
        send_letter(1, 5'd31, 13'd5, 10'd0, 1, 0);       // out of range query
        send_letter(1, 5'd25, 13'd5, 10'd0, 0, 1);       // ignored after stop
        send_letter(1, 5'd25, 13'd4096, 10'd0, 1, 0);
        send_letter(1, 5'd24, 13'd4096, 10'd0, 0, 0);
        send_letter(1, 5'd1, 13'd4096, 10'd0, 0, 1);
        send_letter(0, 5'd25, 13'd1, 10'd300, 0, 1);     // no start: continue walk
        send_letter(0, 5'd25, 13'd2, 10'd301, 1, 0);
        send_letter(1, 5'd24, 13'd2, 10'd301, 0, 0);     // mixed kinds
        send_letter(0, 5'd3, 13'd2, 10'd301, 0, 1);
        send_letter(1, 5'd25, 13'd0, 10'd0, 1, 1);

        // Random stored words over a narrow alphabet so suffixes are shared.
        for (int i = 0; i < 120; i++) begin
            n = $urandom_range(1, 7);
            for (int j = 0; j < 8; j++) w[j] = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) w[0] = $urandom_range(0, 25);
            if (bank_count < 256) begin
                bank[bank_count] = w;
                bank_len[bank_count] = n;
                bank_count++;
            end
            send_word(0, w, n, IDX_W'($urandom_range(0, 1023)), 1);
        end

        // Hold until every insert result is back before querying.
        wait_drained();

        // Queries: a stored word's suffix, sometimes extended with random letters.
        for (int i = 0; i < 260; i++) begin
            b = $urandom_range(0, bank_count - 1);
            k = $urandom_range(1, bank_len[b]);
            w = bank[b];
            n = k;
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(k, 7);
                for (int j = k; j < n; j++) w[j] = $urandom_range(0, 25);
            end
            send_word(1, w, n, IDX_W'($urandom_range(0, 1023)), 1);
        end

        wait_drained();

        // Replay clean stored words as inserts and queries.
        for (int i = 0; i < 20; i++) begin
            b = $urandom_range(0, bank_count - 1);
            send_word(i[0], bank[b], bank_len[b], IDX_W'($urandom_range(0, 1023)), 0);
        end

        wait_drained();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back up the block.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else if (results_seen >= 150 && !long_hold_done) begin
                long_hold_done = 1;
                hold = 400;
                i_m_tready <= 1'b0;
            end else if (pick_gap() == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                hold = pick_gap();
                i_m_tready <= 1'b0;
            end
        end
    end

    // Sample both channels mid-cycle; run the idle watchdog.
    always @(negedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata[IDX_W-1:0], o_m_tuser);
            results_seen <= results_seen + 1;
        end
        if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
